@@ design/rc6_pkg.sv @@
// ----------------------------------------------------------------------------
// rc6_pkg
// Shared types, constants and word functions for the RC6-32 cipher core.
// ----------------------------------------------------------------------------
package rc6_pkg;

  localparam int ROUNDS_DEF        = 20;
  localparam int MAX_KEY_WORDS_DEF = 8;

  localparam logic [31:0] MAGIC_P = 32'hB7E15163;
  localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

  // Configuration register indexes.
  localparam int          CFG_IDX_W   = 3;
  localparam logic [2:0]  CFG_KEY_01  = 3'd0;
  localparam logic [2:0]  CFG_KEY_23  = 3'd1;
  localparam logic [2:0]  CFG_KEY_45  = 3'd2;
  localparam logic [2:0]  CFG_KEY_67  = 3'd3;
  localparam logic [2:0]  CFG_KEY_CNT = 3'd4;
  localparam int          KEY_REGS    = 4;
  localparam logic [3:0]  KEY_CNT_RST = 4'd4;

  localparam logic [0:0]  CMD_ENCRYPT = 1'b0;
  localparam logic [0:0]  CMD_DECRYPT = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] block_low;
    logic [63:0] block_high;
  } rc6_in_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
  } rc6_out_t;

  // Strobes from the sequencer to the round datapath.
  typedef struct packed {
    logic load;
    logic pre;
    logic mix;
    logic upd;
    logic post;
    logic decrypt;
  } rc6_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_PRE_RD,
    ST_PRE,
    ST_MIX,
    ST_UPD,
    ST_POST
  } rc6_state_t;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_MIX_A,
    KS_MIX_B
  } ks_state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

  // rotl(x * (2x + 1), 5), all modulo 2^32.
  function automatic logic [31:0] mix32(input logic [31:0] x);
    logic [31:0] p;
    p = x * {x[30:0], 1'b1};
    return rotl32(p, 5'd5);
  endfunction

endpackage

@@ design/rc6_key_sched.sv @@
// ----------------------------------------------------------------------------
// rc6_key_sched
// Key expansion sequencer and round key memory. Runs the mixing pass one half
// step per cycle and serves two registered read ports to the cipher datapath.
// ----------------------------------------------------------------------------
module rc6_key_sched #(
  parameter int ROUNDS        = rc6_pkg::ROUNDS_DEF,
  parameter int MAX_KEY_WORDS = rc6_pkg::MAX_KEY_WORDS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [rc6_pkg::KEY_REGS-1:0][63:0]    key_words,
  input  logic [3:0]                            key_cnt,
  input  logic [$clog2(ROUNDS+2)-1:0]           pair_idx,
  output logic                                  done,
  output logic [31:0]                           rk_even,
  output logic [31:0]                           rk_odd
);

  localparam int RK = 2 * ROUNDS + 4;
  localparam int XW = $clog2(ROUNDS + 2);
  localparam int AW = XW + 1;
  localparam int JW = $clog2(MAX_KEY_WORDS);
  localparam int CW = $clog2(MAX_KEY_WORDS + 1);
  localparam int MV = (RK > MAX_KEY_WORDS) ? RK : MAX_KEY_WORDS;
  localparam int SW = $clog2(3 * MV + 1);

  rc6_pkg::ks_state_t state_r, state_nxt;

  logic [AW-1:0] i_r;
  logic [JW-1:0] j_r;
  logic [SW-1:0] k_r;
  logic [SW-1:0] nsteps_r;
  logic [CW-1:0] c_r;
  logic [31:0]   a_r, b_r, q_r;
  logic [31:0]   l_r [MAX_KEY_WORDS];
  logic [31:0]   mem_r [RK];
  logic [31:0]   rd0_r, rd1_r;

  logic [CW-1:0] c_sat;
  logic [SW-1:0] m_val;
  logic          first_pass;
  logic [31:0]   s_in, a_sum, a_new, ab_sum, b_new;
  logic [AW-1:0] i_nxt;
  logic [JW-1:0] j_nxt;
  logic          last_step;
  logic          do_load, mem_we, do_b;
  logic [AW-1:0] rd0_addr, rd1_addr;

  // Key word count of zero acts as one; counts above the scratch depth saturate.
  always_comb begin
    if (key_cnt == 4'd0) begin
      c_sat = CW'(1);
    end else if (key_cnt > 4'(MAX_KEY_WORDS)) begin
      c_sat = CW'(MAX_KEY_WORDS);
    end else begin
      c_sat = CW'(key_cnt);
    end
    m_val = (SW'(c_sat) > SW'(RK)) ? SW'(c_sat) : SW'(RK);
  end

  // During the first pass over the table the entry still holds its magic fill,
  // which q_r tracks, so no fill sweep is needed.
  assign first_pass = k_r < SW'(RK);
  assign s_in       = first_pass ? q_r : rd0_r;
  assign a_sum      = s_in + a_r + b_r;
  assign a_new      = rc6_pkg::rotl32(a_sum, 5'd3);
  assign ab_sum     = a_r + b_r;
  assign b_new      = rc6_pkg::rotl32(l_r[j_r] + ab_sum, ab_sum[4:0]);
  assign i_nxt      = (i_r == AW'(RK - 1)) ? '0 : i_r + AW'(1);
  assign j_nxt      = ((CW'(j_r) + CW'(1)) == c_r) ? '0 : j_r + JW'(1);
  assign last_step  = k_r == (nsteps_r - SW'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rc6_pkg::KS_IDLE:  if (start) state_nxt = rc6_pkg::KS_LOAD;
      rc6_pkg::KS_LOAD:  state_nxt = rc6_pkg::KS_MIX_A;
      rc6_pkg::KS_MIX_A: state_nxt = rc6_pkg::KS_MIX_B;
      rc6_pkg::KS_MIX_B: state_nxt = last_step ? rc6_pkg::KS_IDLE : rc6_pkg::KS_MIX_A;
      default:           state_nxt = rc6_pkg::KS_IDLE;
    endcase
  end

  always_comb begin
    do_load  = 1'b0;
    mem_we   = 1'b0;
    do_b     = 1'b0;
    done     = 1'b0;
    rd0_addr = {pair_idx, 1'b0};
    case (state_r)
      rc6_pkg::KS_LOAD: begin
        do_load  = 1'b1;
        rd0_addr = '0;
      end
      rc6_pkg::KS_MIX_A: begin
        mem_we = 1'b1;
      end
      rc6_pkg::KS_MIX_B: begin
        do_b     = 1'b1;
        done     = last_step;
        rd0_addr = i_nxt;
      end
      default: begin
        do_load = 1'b0;
      end
    endcase
  end

  assign rd1_addr = {pair_idx, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc6_pkg::KS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      for (int n = 0; n < MAX_KEY_WORDS; n++) begin
        l_r[n] <= key_words[n >> 1][(n & 1) * 32 +: 32];
      end
      a_r      <= '0;
      b_r      <= '0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      q_r      <= rc6_pkg::MAGIC_P;
      c_r      <= c_sat;
      nsteps_r <= (m_val << 1) + m_val;
    end else if (mem_we) begin
      a_r <= a_new;
    end else if (do_b) begin
      b_r      <= b_new;
      l_r[j_r] <= b_new;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_r + SW'(1);
      q_r      <= q_r + rc6_pkg::MAGIC_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[i_r] <= a_new;
    end
    rd0_r <= mem_r[rd0_addr];
    rd1_r <= mem_r[rd1_addr];
  end

  assign rk_even = rd0_r;
  assign rk_odd  = rd1_r;

endmodule

@@ design/rc6_round_unit.sv @@
// ----------------------------------------------------------------------------
// rc6_round_unit
// Word registers A..D and the shared round logic: a mix step forms t and u,
// and an update step then applies the round keys and rotates the words.
// ----------------------------------------------------------------------------
module rc6_round_unit (
  input  logic                clk,
  input  rc6_pkg::rc6_ctrl_t  ctrl,
  input  rc6_pkg::rc6_in_t    blk,
  input  logic [31:0]         rk_even,
  input  logic [31:0]         rk_odd,
  output rc6_pkg::rc6_out_t   result
);

  logic [31:0] a_r, b_r, c_r, d_r, t_r, u_r;
  logic [31:0] enc_a, enc_c, dec_a, dec_c;

  always_comb begin
    enc_a = rc6_pkg::rotl32(a_r ^ t_r, u_r[4:0]) + rk_even;
    enc_c = rc6_pkg::rotl32(c_r ^ u_r, t_r[4:0]) + rk_odd;
    dec_a = rc6_pkg::rotr32(d_r - rk_even, u_r[4:0]) ^ t_r;
    dec_c = rc6_pkg::rotr32(b_r - rk_odd, t_r[4:0]) ^ u_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_r <= blk.block_low[31:0];
      b_r <= blk.block_low[63:32];
      c_r <= blk.block_high[31:0];
      d_r <= blk.block_high[63:32];
    end else if (ctrl.pre) begin
      if (ctrl.decrypt) begin
        a_r <= a_r - rk_even;
        c_r <= c_r - rk_odd;
      end else begin
        b_r <= b_r + rk_even;
        d_r <= d_r + rk_odd;
      end
    end else if (ctrl.mix) begin
      // Decryption undoes the word rotation first, so t and u come from A and C.
      if (ctrl.decrypt) begin
        t_r <= rc6_pkg::mix32(a_r);
        u_r <= rc6_pkg::mix32(c_r);
      end else begin
        t_r <= rc6_pkg::mix32(b_r);
        u_r <= rc6_pkg::mix32(d_r);
      end
    end else if (ctrl.upd) begin
      if (ctrl.decrypt) begin
        a_r <= dec_a;
        b_r <= a_r;
        c_r <= dec_c;
        d_r <= c_r;
      end else begin
        a_r <= b_r;
        b_r <= enc_c;
        c_r <= d_r;
        d_r <= enc_a;
      end
    end else if (ctrl.post) begin
      if (ctrl.decrypt) begin
        b_r <= b_r - rk_even;
        d_r <= d_r - rk_odd;
      end else begin
        a_r <= a_r + rk_even;
        c_r <= c_r + rk_odd;
      end
    end
  end

  assign result.result_low  = {b_r, a_r};
  assign result.result_high = {d_r, c_r};

endmodule

@@ design/rc6_block_cipher_core.sv @@
// ----------------------------------------------------------------------------
// rc6_block_cipher_core
// RC6-32 block cipher with on-chip key expansion.
// ----------------------------------------------------------------------------
// Usage: write the key through the cfg_ port (cfg_we, cfg_index, cfg_wdata)
// while the core is idle. Registers 0..3 hold key words in pairs, register 4
// holds the key word count. Any write to one of them marks the round keys stale.
// A block beat is taken when start is high and busy is low; in_data.cmd picks
// encrypt or decrypt. The result is shown on out_data for one cycle with
// out_strobe high; the receiver must take it then, it cannot hold it off.
// Sequence: the accepting edge loads the block, a read step fetches and a pre
// step applies the input whitening keys, each round runs in the shared round
// unit as a t/u multiply step, then an update step, and a post step applies
// the output whitening; out_strobe is registered from the post step. A new
// beat can start in the strobe cycle. The first beat after reset or after a
// key write also runs key expansion first: a load step, then the mixing pass
// at one half step per cycle against the single-write round key memory.
// Synchronous reset returns the core to idle, clears the key registers, sets
// the key word count to four and marks the round keys stale.
// ----------------------------------------------------------------------------
module rc6_block_cipher_core #(
  parameter int ROUNDS        = rc6_pkg::ROUNDS_DEF,
  parameter int MAX_KEY_WORDS = rc6_pkg::MAX_KEY_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  rc6_pkg::rc6_in_t                  in_data,
  output logic                              busy,
  output logic                              out_strobe,
  output rc6_pkg::rc6_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [rc6_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_wdata
);

  localparam int XW = $clog2(ROUNDS + 2);
  localparam logic [XW-1:0] X_FIRST = XW'(1);
  localparam logic [XW-1:0] X_LAST  = XW'(ROUNDS);
  localparam logic [XW-1:0] X_OUTER = XW'(ROUNDS + 1);

  rc6_pkg::rc6_state_t state_r, state_nxt;

  logic [rc6_pkg::KEY_REGS-1:0][63:0] key_regs_r;
  logic [3:0]                         key_cnt_r;
  logic                               sched_valid_r;
  logic                               out_strobe_r;
  logic                               decrypt_r;
  logic [XW-1:0]                      rnd_r;

  logic               accept;
  logic               last_round;
  logic               ks_start, ks_done;
  logic [XW-1:0]      pair_idx;
  logic [31:0]        rk_even, rk_odd;
  rc6_pkg::rc6_ctrl_t ctrl;

  assign accept     = start && !busy;
  assign last_round = decrypt_r ? (rnd_r == X_FIRST) : (rnd_r == X_LAST);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rc6_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = sched_valid_r ? rc6_pkg::ST_PRE_RD : rc6_pkg::ST_KEY;
        end
      end
      rc6_pkg::ST_KEY:    if (ks_done) state_nxt = rc6_pkg::ST_PRE_RD;
      rc6_pkg::ST_PRE_RD: state_nxt = rc6_pkg::ST_PRE;
      rc6_pkg::ST_PRE:    state_nxt = rc6_pkg::ST_MIX;
      rc6_pkg::ST_MIX:    state_nxt = rc6_pkg::ST_UPD;
      rc6_pkg::ST_UPD:    state_nxt = last_round ? rc6_pkg::ST_POST : rc6_pkg::ST_MIX;
      rc6_pkg::ST_POST:   state_nxt = rc6_pkg::ST_IDLE;
      default:            state_nxt = rc6_pkg::ST_IDLE;
    endcase
  end

  // Round keys come in pairs: pair x holds keys 2x and 2x+1. The read data is
  // registered, so each address goes out in the state before the one that uses it.
  always_comb begin
    busy         = 1'b1;
    ks_start     = 1'b0;
    ctrl         = '0;
    ctrl.decrypt = decrypt_r;
    pair_idx     = '0;
    case (state_r)
      rc6_pkg::ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = accept;
        ks_start  = accept && !sched_valid_r;
      end
      rc6_pkg::ST_PRE_RD: begin
        pair_idx = decrypt_r ? X_OUTER : '0;
      end
      rc6_pkg::ST_PRE: begin
        ctrl.pre = 1'b1;
      end
      rc6_pkg::ST_MIX: begin
        ctrl.mix = 1'b1;
        pair_idx = rnd_r;
      end
      rc6_pkg::ST_UPD: begin
        ctrl.upd = 1'b1;
        pair_idx = decrypt_r ? '0 : X_OUTER;
      end
      rc6_pkg::ST_POST: begin
        ctrl.post = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rc6_pkg::ST_IDLE;
      key_regs_r    <= '0;
      key_cnt_r     <= rc6_pkg::KEY_CNT_RST;
      sched_valid_r <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= state_r == rc6_pkg::ST_POST;
      if (cfg_we) begin
        case (cfg_index)
          rc6_pkg::CFG_KEY_01: begin
            key_regs_r[0] <= cfg_wdata;
            sched_valid_r <= 1'b0;
          end
          rc6_pkg::CFG_KEY_23: begin
            key_regs_r[1] <= cfg_wdata;
            sched_valid_r <= 1'b0;
          end
          rc6_pkg::CFG_KEY_45: begin
            key_regs_r[2] <= cfg_wdata;
            sched_valid_r <= 1'b0;
          end
          rc6_pkg::CFG_KEY_67: begin
            key_regs_r[3] <= cfg_wdata;
            sched_valid_r <= 1'b0;
          end
          rc6_pkg::CFG_KEY_CNT: begin
            key_cnt_r     <= cfg_wdata[3:0];
            sched_valid_r <= 1'b0;
          end
          default: begin
            sched_valid_r <= sched_valid_r;
          end
        endcase
      end else if (state_r == rc6_pkg::ST_KEY && ks_done) begin
        sched_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      decrypt_r <= in_data.cmd == rc6_pkg::CMD_DECRYPT;
    end
    if (state_r == rc6_pkg::ST_PRE) begin
      rnd_r <= decrypt_r ? X_LAST : X_FIRST;
    end else if (state_r == rc6_pkg::ST_UPD) begin
      rnd_r <= decrypt_r ? rnd_r - XW'(1) : rnd_r + XW'(1);
    end
  end

  rc6_key_sched #(
    .ROUNDS        (ROUNDS),
    .MAX_KEY_WORDS (MAX_KEY_WORDS)
  ) u_key_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ks_start),
    .key_words (key_regs_r),
    .key_cnt   (key_cnt_r),
    .pair_idx  (pair_idx),
    .done      (ks_done),
    .rk_even   (rk_even),
    .rk_odd    (rk_odd)
  );

  rc6_round_unit u_round (
    .clk     (clk),
    .ctrl    (ctrl),
    .blk     (in_data),
    .rk_even (rk_even),
    .rk_odd  (rk_odd),
    .result  (out_data)
  );

  assign out_strobe = out_strobe_r;

endmodule

@@ design/rc6_chk.sv @@
// ----------------------------------------------------------------------------
// rc6_chk
// Port-level checks for the cipher core: beat and strobe sequencing.
// ----------------------------------------------------------------------------
module rc6_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  // A result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("out_strobe held for more than one cycle");

  // An accepted beat makes the core busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("core not busy after an accepted beat");

  // The result appears once the core is free again.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // Outside reset, busy only drops when the result is delivered.
  a_busy_drop: assert property (@(posedge clk)
    (rst_n && $past(rst_n) && $fell(busy)) |-> out_strobe)
    else $error("busy dropped without a result");

  // Reset leaves the core idle with no pending result.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe))
    else $error("core not idle after reset");

endmodule

bind rc6_block_cipher_core rc6_chk u_rc6_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);
